FILE: rtl/ntt_pkg.sv
// shared types and constants of the nat translation table
package ntt_pkg;

  localparam int IN_W      = 160;
  localparam int OUT_W     = 216;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [2:0] CMD_OUT   = 3'd0;
  localparam logic [2:0] CMD_IN    = 3'd1;
  localparam logic [2:0] CMD_EXP   = 3'd2;
  localparam logic [2:0] CMD_CLRST = 3'd3;
  localparam logic [2:0] CMD_INIT  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PORT_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_LAST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TO_ICMP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TO_UDP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TO_TCP     = 3'd4;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;

  localparam logic [15:0] PORT_FIRST_RST = 16'd20000;
  localparam logic [15:0] PORT_LAST_RST  = 16'd30000;
  localparam logic [15:0] TO_ICMP_RST    = 16'd60;
  localparam logic [15:0] TO_UDP_RST     = 16'd300;
  localparam logic [15:0] TO_TCP_RST     = 16'd300;

  // x / 1000 == (x * MS_RECIP) >> MS_SHIFT for every 32-bit x
  localparam logic [31:0] MS_RECIP = 32'd274877907;
  localparam int          MS_SHIFT = 38;
  localparam int          SEC_W    = 23;

  localparam int CNT_OUT = 0;
  localparam int CNT_IN  = 1;
  localparam int CNT_FUL = 2;
  localparam int CNT_UNM = 3;
  localparam int CNT_EXP = 4;
  localparam int NCNT    = 5;

  localparam int BKT_MAX_W = 7;

  typedef struct packed {
    logic [BKT_MAX_W-1:0] bkt;
    logic [15:0]          life;
    logic [SEC_W-1:0]     last;
    logic [15:0]          pport;
    logic [47:0]          rem;
    logic [47:0]          lan;
    logic [7:0]           proto;
  } slot_t;

  localparam int ENT_W = $bits(slot_t);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_BKT  = 7'b0000100,
    S_BSEL = 7'b0001000,
    S_BCHK = 7'b0010000,
    S_SCAN = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

endpackage

FILE: rtl/nat_translation_table_core.sv
// source nat translation table: top level with control sequencer
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_tvalid/in_tready   | in_tdata: one request
//   out_    | out | out_tvalid/out_tready | out_tdata: one result per request
//   cfg_    | in  | cfg_we                | cfg_index, cfg_wdata
//
// outbound and expire requests pass through prep, one pass over the slot ram at one read
// per cycle, and finish, and only then does the block return to idle and take the next request.
// inbound first checks the slot named by its bucket hint, if any, and scans only when that misses.
// clear statistics, init and unused commands go from prep straight to finish.
// reset clears valid bits and counters and loads the cursor and config registers with defaults.
// a stalled result holds in the output register while the next request is taken.
module nat_translation_table_core #(
  parameter int TABLE_ENTRIES = 32,
  parameter int BUCKETS       = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // command, ip_protocol, lan_address, lan_port_number, remote_address,
  // remote_port_number, public_port, now_ticks, zero fill
  input  logic [ntt_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // status, mapped_address, mapped_port, expired_count, count_outbound,
  // count_inbound, count_full, count_unmatched, count_expired
  output logic [ntt_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_we,
  input  logic [ntt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ntt_pkg::CFG_W-1:0]     cfg_wdata
);
  import ntt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  state_t state_r;

  logic [15:0] port_first_r, port_last_r, to_icmp_r, to_udp_r, to_tcp_r;
  logic [15:0] cursor_r, cursor_nxt;

  logic [2:0]       cmd_r;
  logic [7:0]       proto_r;
  logic [47:0]      lan_key_r, rem_key_r;
  logic [15:0]      pport_r;
  logic [SEC_W-1:0] now_sec_r;
  logic [63:0]      now_prod;
  logic [BW-1:0]    bkt_r;

  logic [TABLE_ENTRIES-1:0] slot_vld_r;
  logic [BUCKETS-1:0]       bkt_vld_r;

  logic [CW-1:0] scan_ptr_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  logic          hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  slot_t         hit_ent_r;
  logic [5:0]    exp_cnt_r;

  logic [31:0] cnt_r   [NCNT];
  logic [31:0] cnt_nxt [NCNT];

  logic                 out_tvalid_r;
  logic [OUT_W-1:0]     out_tdata_r;

  // remainder unit
  logic          mod_start;
  logic [15:0]   mod_value;
  logic [BW-1:0] mod_rem;

  // memories
  logic          slot_we;
  logic [IW-1:0] slot_waddr, slot_raddr;
  logic [ENT_W-1:0] slot_wdata, slot_rdata;
  logic          bkt_we;
  logic [IW-1:0] bkt_rdata;
  slot_t         ent, new_ent;

  logic       in_acc, fin_go, fwd_match, rev_match, expire, alloc;
  logic [SEC_W:0] age;
  logic [15:0] life_sel;
  logic [1:0]  fin_status;
  logic [31:0] fin_maddr;
  logic [15:0] fin_mport;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign fin_go    = (state_r == S_FIN) && (!out_tvalid_r || out_tready);
  assign mod_start = in_acc;
  assign mod_value = (in_tdata[2:0] == CMD_OUT) ? cursor_r : in_tdata[122:107];
  assign now_prod  = 64'(in_tdata[154:123]) * 64'(MS_RECIP);

  ntt_mod #(.DIVISOR(BUCKETS)) u_mod (
    .clk   (clk),
    .start (mod_start),
    .value (mod_value),
    .rem   (mod_rem)
  );

  ntt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ntt_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_r),
    .wdata (free_idx_r),
    .raddr (bkt_r),
    .rdata (bkt_rdata)
  );

  always_comb begin
    ent        = slot_t'(slot_rdata);
    slot_raddr = (state_r == S_BSEL) ? bkt_rdata : scan_ptr_r[IW-1:0];
    fwd_match  = slot_vld_r[cmp_idx_r] && (ent.proto == proto_r) &&
                 (ent.lan == lan_key_r) && (ent.rem == rem_key_r);
    rev_match  = slot_vld_r[cmp_idx_r] && (ent.proto == proto_r) &&
                 (ent.pport == pport_r) && (ent.rem == rem_key_r);
    // seconds are below 2^23, so a negative difference is a huge wrapped age
    age        = {1'b0, now_sec_r} - {1'b0, ent.last};
    expire     = age[SEC_W] || (age[SEC_W-1:0] >= SEC_W'(ent.life));
  end

  always_comb begin
    if (proto_r == PROTO_ICMP) begin
      life_sel = to_icmp_r;
    end else if (proto_r == PROTO_TCP) begin
      life_sel = to_tcp_r;
    end else begin
      life_sel = to_udp_r;
    end
    new_ent.bkt   = BKT_MAX_W'(bkt_r);
    new_ent.life  = life_sel;
    new_ent.last  = now_sec_r;
    new_ent.pport = cursor_r;
    new_ent.rem   = rem_key_r;
    new_ent.lan   = lan_key_r;
    new_ent.proto = proto_r;
  end

  // result and write-back of the finishing request
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = hit_idx_r;
    slot_wdata = {hit_ent_r.bkt, hit_ent_r.life, now_sec_r, hit_ent_r.pport,
                  hit_ent_r.rem, hit_ent_r.lan, hit_ent_r.proto};
    bkt_we     = 1'b0;
    alloc      = 1'b0;
    cursor_nxt = cursor_r + 16'd1;
    if (cursor_nxt > port_last_r) begin
      cursor_nxt = port_first_r;
    end
    fin_status = ST_OK;
    fin_maddr  = '0;
    fin_mport  = '0;
    for (int k = 0; k < NCNT; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end
    case (cmd_r) inside
      CMD_OUT: begin
        if (hit_r) begin
          slot_we             = fin_go;
          fin_mport           = hit_ent_r.pport;
          cnt_nxt[CNT_OUT]    = cnt_r[CNT_OUT] + 32'd1;
        end else if (free_r) begin
          alloc               = 1'b1;
          slot_we             = fin_go;
          slot_waddr          = free_idx_r;
          slot_wdata          = new_ent;
          bkt_we              = fin_go;
          fin_mport           = cursor_r;
          cnt_nxt[CNT_OUT]    = cnt_r[CNT_OUT] + 32'd1;
        end else begin
          fin_status          = ST_FULL;
          cnt_nxt[CNT_FUL]    = cnt_r[CNT_FUL] + 32'd1;
        end
      end
      CMD_IN: begin
        if (hit_r) begin
          slot_we             = fin_go;
          fin_maddr           = hit_ent_r.lan[47:16];
          fin_mport           = hit_ent_r.lan[15:0];
          cnt_nxt[CNT_IN]     = cnt_r[CNT_IN] + 32'd1;
        end else begin
          fin_status          = ST_NOMATCH;
          cnt_nxt[CNT_UNM]    = cnt_r[CNT_UNM] + 32'd1;
        end
      end
      CMD_CLRST, CMD_INIT: begin
        for (int k = 0; k < NCNT; k++) begin
          cnt_nxt[k] = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      port_first_r <= PORT_FIRST_RST;
      port_last_r  <= PORT_LAST_RST;
      to_icmp_r    <= TO_ICMP_RST;
      to_udp_r     <= TO_UDP_RST;
      to_tcp_r     <= TO_TCP_RST;
      cursor_r     <= PORT_FIRST_RST;
      slot_vld_r   <= '0;
      bkt_vld_r    <= '0;
      scan_ptr_r   <= '0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      exp_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
      for (int k = 0; k < NCNT; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PORT_FIRST: port_first_r <= cfg_wdata;
          REG_PORT_LAST:  port_last_r  <= cfg_wdata;
          REG_TO_ICMP:    to_icmp_r    <= cfg_wdata;
          REG_TO_UDP:     to_udp_r     <= cfg_wdata;
          REG_TO_TCP:     to_tcp_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid_r && out_tready && !fin_go) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r     <= in_tdata[2:0];
            proto_r   <= in_tdata[10:3];
            lan_key_r <= {in_tdata[42:11], in_tdata[58:43]};
            rem_key_r <= {in_tdata[90:59], in_tdata[106:91]};
            pport_r   <= in_tdata[122:107];
            now_sec_r <= now_prod[MS_SHIFT+SEC_W-1:MS_SHIFT];
            state_r   <= S_PREP;
          end
        end
        S_PREP: begin
          bkt_r      <= mod_rem;
          hit_r      <= 1'b0;
          free_r     <= 1'b0;
          exp_cnt_r  <= '0;
          scan_ptr_r <= '0;
          cmp_vld_r  <= 1'b0;
          case (cmd_r) inside
            CMD_OUT, CMD_EXP: state_r <= S_SCAN;
            CMD_IN:           state_r <= S_BKT;
            default:          state_r <= S_FIN;
          endcase
        end
        S_BKT: begin
          state_r <= S_BSEL;
        end
        S_BSEL: begin
          // bucket hint: check the slot it names before scanning
          if (bkt_vld_r[bkt_r]) begin
            cmp_idx_r <= bkt_rdata;
            state_r   <= S_BCHK;
          end else begin
            state_r   <= S_SCAN;
          end
        end
        S_BCHK: begin
          if (rev_match) begin
            hit_r     <= 1'b1;
            hit_idx_r <= cmp_idx_r;
            hit_ent_r <= ent;
            state_r   <= S_FIN;
          end else begin
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_ptr_r < CW'(TABLE_ENTRIES)) begin
            scan_ptr_r <= scan_ptr_r + CW'(1);
            cmp_vld_r  <= 1'b1;
            cmp_idx_r  <= scan_ptr_r[IW-1:0];
          end else begin
            cmp_vld_r  <= 1'b0;
          end
          if (cmp_vld_r) begin
            case (cmd_r)
              CMD_OUT: begin
                if (!hit_r && fwd_match) begin
                  hit_r     <= 1'b1;
                  hit_idx_r <= cmp_idx_r;
                  hit_ent_r <= ent;
                end
                if (!free_r && !slot_vld_r[cmp_idx_r]) begin
                  free_r     <= 1'b1;
                  free_idx_r <= cmp_idx_r;
                end
              end
              CMD_IN: begin
                if (!hit_r && rev_match) begin
                  hit_r     <= 1'b1;
                  hit_idx_r <= cmp_idx_r;
                  hit_ent_r <= ent;
                end
              end
              CMD_EXP: begin
                if (slot_vld_r[cmp_idx_r] && expire) begin
                  slot_vld_r[cmp_idx_r]       <= 1'b0;
                  bkt_vld_r[ent.bkt[BW-1:0]] <= 1'b0;
                  exp_cnt_r                   <= exp_cnt_r + 6'd1;
                  cnt_r[CNT_EXP]              <= cnt_r[CNT_EXP] + 32'd1;
                end
              end
              default: ;
            endcase
          end
          if ((scan_ptr_r == CW'(TABLE_ENTRIES)) && !cmp_vld_r) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            for (int k = 0; k < NCNT; k++) begin
              cnt_r[k] <= cnt_nxt[k];
            end
            if (cmd_r == CMD_INIT) begin
              slot_vld_r <= '0;
              bkt_vld_r  <= '0;
              cursor_r   <= port_first_r;
            end
            if (alloc) begin
              slot_vld_r[free_idx_r] <= 1'b1;
              bkt_vld_r[bkt_r]       <= 1'b1;
              cursor_r               <= cursor_nxt;
            end
            out_tdata_r  <= {cnt_nxt[CNT_EXP], cnt_nxt[CNT_UNM], cnt_nxt[CNT_FUL],
                             cnt_nxt[CNT_IN], cnt_nxt[CNT_OUT], exp_cnt_r,
                             fin_mport, fin_maddr, fin_status};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_PREP))
    else $error("accepted request did not start");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && out_tvalid_r && !out_tready) |=> (state_r == S_FIN))
    else $error("result left while output register busy");

  a_full_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && (cmd_r == CMD_OUT) && !hit_r && !free_r) |-> (&slot_vld_r))
    else $error("table full reported with a free slot");
`endif
endmodule

FILE: rtl/ntt_ram.sv
// generic single-write, single-read ram with registered read
module ntt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/ntt_mod.sv
// registered remainder of a 16-bit value by a constant, by reciprocal multiplication
module ntt_mod #(
  parameter int DIVISOR = 128
) (
  input  logic                                           clk,
  input  logic                                           start,
  input  logic [15:0]                                    value,
  output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] rem
);
  localparam int RW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
  localparam int SH = 16 + RW;
  // ceil(2^SH / DIVISOR) gives the exact quotient for every 16-bit value when DIVISOR > 1
  localparam logic [16:0] RECIP =
    17'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [32:0]   prod;
  logic [15:0]   quo;
  logic [15:0]   back;
  logic [15:0]   diff;
  logic [RW-1:0] rem_r;

  always_comb begin
    prod = 33'(value) * 33'(RECIP);
    quo  = 16'(prod >> SH);
    back = quo * 16'(DIVISOR);
    diff = value - back;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= diff[RW-1:0];
    end
  end

  assign rem = rem_r;
endmodule

FILE: sim/testbench.sv
// testbench for the nat translation table: directed and random requests checked
// against a behavioral predictor of the table
`timescale 1ns / 1ps

module testbench;
  import ntt_pkg::*;

  localparam int NSLOT     = 32;
  localparam int NBKT      = 128;
  localparam int WDOG_MAX  = 6000;
  localparam int SETTLE    = 120;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [7:0] BKT_NONE    = 8'h80;
  localparam logic [2:0] CMD_UNUSED5 = 3'd5;
  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;

  // request layout from bit 0 up: cmd, proto, lan address, lan port, remote
  // address, remote port, public port, now ticks, zero fill
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] now;
    logic [15:0] pport;
    logic [15:0] rport;
    logic [31:0] raddr;
    logic [15:0] lport;
    logic [31:0] laddr;
    logic [7:0]  proto;
    logic [2:0]  cmd;
  } req_t;

  // result layout from bit 0 up: status, mapped address, mapped port,
  // expired count, then the five counters
  typedef struct packed {
    logic [31:0] c_exp;
    logic [31:0] c_unm;
    logic [31:0] c_full;
    logic [31:0] c_in;
    logic [31:0] c_out;
    logic [5:0]  nexp;
    logic [15:0] mport;
    logic [31:0] maddr;
    logic [1:0]  st;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_we;
  logic [IN_W-1:0] in_tdata;
  logic [OUT_W-1:0] out_tdata;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  always #4 clk = ~clk;

  nat_translation_table_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predicted table state
  logic        tbl_valid [NSLOT];
  logic [7:0]  tbl_proto [NSLOT];
  logic [47:0] tbl_lan   [NSLOT];
  logic [47:0] tbl_rem   [NSLOT];
  logic [15:0] tbl_pport [NSLOT];
  logic [31:0] tbl_seen  [NSLOT];
  logic [15:0] tbl_life  [NSLOT];
  logic [7:0]  tbl_bucket [NBKT];
  logic [15:0] port_cursor;
  logic [31:0] stats [5];
  logic [15:0] reg_first, reg_last, reg_icmp, reg_udp, reg_tcp;

  result_t pending_results [$];
  int err_count = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int quiet_cycles = 0;
  logic [31:0] now_ms = 32'd0;
  logic [47:0] lan_pool [8];
  logic [47:0] rem_pool [8];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic void table_clear();
    for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
    for (int b = 0; b < NBKT; b++) tbl_bucket[b] = BKT_NONE;
    for (int c = 0; c < 5; c++) stats[c] = 32'd0;
  endfunction

  function automatic result_t nat_predict(req_t r);
    result_t res;
    int hit;
    logic [47:0] lkey, rkey;
    logic [7:0] b;
    logic [31:0] age;
    hit = -1;
    res = '0;
    lkey = {r.laddr, r.lport};
    rkey = {r.raddr, r.rport};
    case (r.cmd)
      CMD_OUT: begin
        for (int i = 0; i < NSLOT && hit < 0; i++)
          if (tbl_valid[i] && tbl_proto[i] == r.proto && tbl_lan[i] == lkey &&
              tbl_rem[i] == rkey) hit = i;
        if (hit < 0) begin
          for (int i = 0; i < NSLOT && hit < 0; i++)
            if (!tbl_valid[i]) hit = i;
          if (hit < 0) begin
            res.st = ST_FULL;
            stats[CNT_FUL]++;
          end else begin
            tbl_pport[hit] = port_cursor;
            port_cursor = port_cursor + 16'd1;
            if (port_cursor > reg_last) port_cursor = reg_first;
            tbl_valid[hit] = 1'b1;
            tbl_proto[hit] = r.proto;
            tbl_lan[hit] = lkey;
            tbl_rem[hit] = rkey;
            tbl_seen[hit] = r.now;
            tbl_life[hit] = (r.proto == PROTO_ICMP) ? reg_icmp :
                            (r.proto == PROTO_TCP) ? reg_tcp : reg_udp;
            tbl_bucket[tbl_pport[hit] % NBKT] = 8'(hit);
          end
        end else begin
          tbl_seen[hit] = r.now;
        end
        if (hit >= 0) begin
          res.mport = tbl_pport[hit];
          stats[CNT_OUT]++;
        end
      end
      CMD_IN: begin
        b = tbl_bucket[r.pport % NBKT];
        if (b < NSLOT && tbl_valid[b] && tbl_proto[b] == r.proto &&
            tbl_pport[b] == r.pport && tbl_rem[b] == rkey) hit = b;
        for (int i = 0; i < NSLOT && hit < 0; i++)
          if (tbl_valid[i] && tbl_proto[i] == r.proto && tbl_pport[i] == r.pport &&
              tbl_rem[i] == rkey) hit = i;
        if (hit < 0) begin
          res.st = ST_NOMATCH;
          stats[CNT_UNM]++;
        end else begin
          tbl_seen[hit] = r.now;
          res.maddr = tbl_lan[hit][47:16];
          res.mport = tbl_lan[hit][15:0];
          stats[CNT_IN]++;
        end
      end
      CMD_EXP: begin
        for (int j = 0; j < NSLOT; j++) begin
          if (tbl_valid[j]) begin
            age = r.now / 1000 - tbl_seen[j] / 1000;
            if (age >= {16'd0, tbl_life[j]}) begin
              tbl_bucket[tbl_pport[j] % NBKT] = BKT_NONE;
              tbl_valid[j] = 1'b0;
              res.nexp++;
              stats[CNT_EXP]++;
            end
          end
        end
      end
      CMD_CLRST: for (int c = 0; c < 5; c++) stats[c] = 32'd0;
      CMD_INIT: begin
        table_clear();
        port_cursor = reg_first;
      end
      default: ;
    endcase
    res.c_out = stats[CNT_OUT];
    res.c_in = stats[CNT_IN];
    res.c_full = stats[CNT_FUL];
    res.c_unm = stats[CNT_UNM];
    res.c_exp = stats[CNT_EXP];
    return res;
  endfunction

  task automatic send_request(input req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    r.pad = '0;
    in_tdata = r;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(nat_predict(r));
  endtask

  // lets every result drain and the block go idle
  task automatic wait_drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_PORT_FIRST: reg_first = val;
      REG_PORT_LAST:  reg_last = val;
      REG_TO_ICMP:    reg_icmp = val;
      REG_TO_UDP:     reg_udp = val;
      REG_TO_TCP:     reg_tcp = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] first, input logic [15:0] last,
                          input logic [15:0] ticmp, input logic [15:0] tudp,
                          input logic [15:0] ttcp);
    wait_drain();
    write_reg(REG_PORT_FIRST, first);
    write_reg(REG_PORT_LAST, last);
    write_reg(REG_TO_ICMP, ticmp);
    write_reg(REG_TO_UDP, tudp);
    write_reg(REG_TO_TCP, ttcp);
  endtask

  function automatic req_t mk_req(logic [2:0] cmd, logic [7:0] proto, logic [47:0] lan,
                                  logic [47:0] rem, logic [15:0] pport, logic [31:0] now);
    req_t r;
    r = '0;
    r.cmd = cmd;
    r.proto = proto;
    {r.laddr, r.lport} = lan;
    {r.raddr, r.rport} = rem;
    r.pport = pport;
    r.now = now;
    return r;
  endfunction

  task automatic test_directed();
    logic [47:0] lan_a, rem_a;
    lan_a = 48'hc0a8_0001_1234;
    rem_a = 48'h0808_0808_0035;
    send_request(mk_req(CMD_OUT, PROTO_ICMP, lan_a, rem_a, 16'd0, 32'd1000));
    send_request(mk_req(CMD_OUT, PROTO_ICMP, lan_a, rem_a, 16'd0, 32'd2500));
    send_request(mk_req(CMD_OUT, PROTO_TCP, '1, '1, '1, '1));
    send_request(mk_req(CMD_OUT, 8'd0, '0, '0, '0, '0));
    send_request(mk_req(CMD_OUT, 8'hff, lan_a, rem_a, 16'd0, 32'd3000));
    send_request(mk_req(CMD_OUT, PROTO_UDP, lan_a, rem_a, 16'd0, 32'd3000));
    send_request(mk_req(CMD_IN, PROTO_ICMP, '0, rem_a, 16'd20000, 32'd4000));
    send_request(mk_req(CMD_IN, PROTO_ICMP, '0, ~rem_a, 16'd20000, 32'd4000));
    send_request(mk_req(CMD_IN, PROTO_TCP, '1, '1, '1, '1));
    send_request(mk_req(CMD_IN, PROTO_TCP, '0, '1, 16'd20001, 32'd5000));
    send_request(mk_req(CMD_UNUSED5, PROTO_TCP, '1, '1, '1, '1));
    send_request(mk_req(CMD_UNUSED6, '0, '0, '0, '0, '0));
    send_request(mk_req(CMD_UNUSED7, '1, '1, '1, '1, '1));
    send_request(mk_req(CMD_EXP, '0, '0, '0, '0, 32'd5000));
    send_request(mk_req(CMD_EXP, '0, '0, '0, '0, 32'd65_000));
    send_request(mk_req(CMD_IN, PROTO_ICMP, '0, rem_a, 16'd20000, 32'd70000));
    send_request(mk_req(CMD_CLRST, '0, '0, '0, '0, 32'd70000));
    send_request(mk_req(CMD_OUT, PROTO_UDP, lan_a, rem_a, 16'd0, 32'hffff_fc18));
    send_request(mk_req(CMD_EXP, '0, '0, '0, '0, 32'd200_000));
    send_request(mk_req(CMD_EXP, '0, '0, '0, '0, 32'd400_000));
    send_request(mk_req(CMD_INIT, '0, '0, '0, '0, '0));
    send_request(mk_req(CMD_OUT, PROTO_ICMP, lan_a, rem_a, 16'd0, 32'd10));
  endtask

  task automatic test_table_full();
    send_request(mk_req(CMD_INIT, '0, '0, '0, '0, '0));
    for (int i = 0; i < NSLOT + 2; i++)
      send_request(mk_req(CMD_OUT, PROTO_TCP, {32'h0a00_0000 + i, 16'd80},
                          rem_pool[0], 16'd0, 32'd1000 * i));
    send_request(mk_req(CMD_OUT, PROTO_TCP, {32'h0a00_0005, 16'd80}, rem_pool[0],
                        16'd0, 32'd50000));
    send_request(mk_req(CMD_IN, PROTO_TCP, '0, rem_pool[0], reg_first + 16'd7, 32'd50000));
    // pause until every result is back while the table sits full
    wait_drain();
    send_request(mk_req(CMD_EXP, '0, '0, '0, '0, 32'd340_000));
  endtask

  task automatic test_port_cursor();
    set_regs(16'd65534, 16'd65535, 16'd0, 16'd65535, 16'd0);
    send_request(mk_req(CMD_INIT, '0, '0, '0, '0, '0));
    for (int i = 0; i < 4; i++)
      send_request(mk_req(CMD_OUT, (i == 0) ? PROTO_ICMP : (i == 1) ? PROTO_TCP : PROTO_UDP,
                          lan_pool[i], rem_pool[i], 16'd0, 32'd500));
    send_request(mk_req(CMD_IN, PROTO_UDP, '0, rem_pool[2], 16'd0, 32'd600));
    send_request(mk_req(CMD_EXP, '0, '0, '0, '0, 32'd700));
    set_regs(16'd100, 16'd50, 16'd1, 16'd2, 16'd3);
    send_request(mk_req(CMD_INIT, '0, '0, '0, '0, '0));
    for (int i = 0; i < 3; i++)
      send_request(mk_req(CMD_OUT, PROTO_UDP, lan_pool[i], rem_pool[i], 16'd0, 32'd0));
    send_request(mk_req(CMD_IN, PROTO_UDP, '0, rem_pool[1], 16'd100, 32'd0));
  endtask

  function automatic req_t random_request();
    req_t r;
    int pick, k;
    r = '0;
    {r.laddr, r.lport, r.raddr, r.rport} = {$urandom, $urandom, $urandom};
    r.pport = 16'($urandom);
    r.proto = 8'($urandom);
    pick = $urandom_range(99);
    now_ms = now_ms + $urandom_range(3000);
    if ($urandom_range(199) == 0) now_ms = now_ms + $urandom;
    r.now = now_ms;
    if (pick < 50) begin
      r.cmd = CMD_OUT;
      if ($urandom_range(9) < 7) begin
        {r.laddr, r.lport} = lan_pool[$urandom_range(7)];
        {r.raddr, r.rport} = rem_pool[$urandom_range(7)];
        case ($urandom_range(3))
          0: r.proto = PROTO_ICMP;
          1: r.proto = PROTO_TCP;
          2: r.proto = PROTO_UDP;
          default: ;
        endcase
      end
    end else if (pick < 84) begin
      r.cmd = CMD_IN;
      if ($urandom_range(9) < 7) begin
        for (int t = 0; t < 8; t++) begin
          k = $urandom_range(NSLOT - 1);
          if (tbl_valid[k]) begin
            r.proto = tbl_proto[k];
            r.pport = tbl_pport[k];
            {r.raddr, r.rport} = tbl_rem[k];
            break;
          end
        end
        if ($urandom_range(9) == 0) r.rport[$urandom_range(15)] ^= 1'b1;
      end
    end else if (pick < 95) r.cmd = CMD_EXP;
    else if (pick < 97) r.cmd = CMD_CLRST;
    else if (pick < 98) r.cmd = CMD_INIT;
    else r.cmd = 3'($urandom_range(5, 7));
    return r;
  endfunction

  task automatic test_random(input int count, input int s_idle, input int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int n = 0; n < count; n++) send_request(random_request());
  endtask

  always @(negedge clk) out_tready = ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        report("unexpected result", 32'(got.st), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.st !== want.st) report("status", 32'(got.st), 32'(want.st));
        if (got.maddr !== want.maddr) report("mapped_address", got.maddr, want.maddr);
        if (got.mport !== want.mport)
          report("mapped_port", 32'(got.mport), 32'(want.mport));
        if (got.nexp !== want.nexp)
          report("expired_count", 32'(got.nexp), 32'(want.nexp));
        if (got.c_out !== want.c_out) report("count_outbound", got.c_out, want.c_out);
        if (got.c_in !== want.c_in) report("count_inbound", got.c_in, want.c_in);
        if (got.c_full !== want.c_full) report("count_full", got.c_full, want.c_full);
        if (got.c_unm !== want.c_unm) report("count_unmatched", got.c_unm, want.c_unm);
        if (got.c_exp !== want.c_exp) report("count_expired", got.c_exp, want.c_exp);
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    reg_first = PORT_FIRST_RST;
    reg_last = PORT_LAST_RST;
    reg_icmp = TO_ICMP_RST;
    reg_udp = TO_UDP_RST;
    reg_tcp = TO_TCP_RST;
    port_cursor = PORT_FIRST_RST;
    table_clear();
    for (int i = 0; i < 8; i++) begin
      lan_pool[i] = {$urandom, 16'($urandom)};
      rem_pool[i] = {$urandom, 16'($urandom)};
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_table_full();
    test_port_cursor();
    set_regs(16'd20000, 16'd20063, 16'd3, 16'd6, 16'd12);
    test_random(290, 18, 84);
    set_regs(16'd0, 16'd65535, 16'd65535, 16'd30, 16'd0);
    test_random(290, 84, 18);
    set_regs(16'd65500, 16'd400, 16'd60, 16'd300, 16'd300);
    test_random(290, 0, 0);

    wait_drain();
    if (err_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
